// File: src/bsdf_pkg.sv
// Shared types and constants of the service-data filter with sender dedup.
package bsdf_pkg;

  // Configuration register indexes
  localparam logic CFG_SERVICE_UUID = 1'b0;
  localparam logic CFG_TRIGGER_BYTE = 1'b1;

  localparam logic [15:0] SERVICE_UUID_RST = 16'hFCD2;
  localparam logic [7:0]  TRIGGER_BYTE_RST = 8'h44;

  // AD structure type: service data, 16-bit UUID
  localparam logic [7:0] AD_TYPE_SVC16 = 8'h16;

  // Object type codes inside the service data payload
  localparam logic [7:0] OBJ_PACKET_ID = 8'h00;
  localparam logic [7:0] OBJ_MOVING    = 8'h22;
  localparam logic [7:0] OBJ_SKIP_1B   = 8'h2C;
  localparam logic [7:0] OBJ_SKIP_4B   = 8'h3E;

  // Stored id assumed for a sender not yet in the table
  localparam logic [7:0] NEW_ENTRY_ID = 8'hFF;

  // Walker phase within one AD structure
  typedef enum logic [9:0] {
    PH_LEN      = 10'b00_0000_0001,
    PH_TYPE     = 10'b00_0000_0010,
    PH_UUID_LO  = 10'b00_0000_0100,
    PH_UUID_HI  = 10'b00_0000_1000,
    PH_TRIG     = 10'b00_0001_0000,
    PH_OBJ      = 10'b00_0010_0000,
    PH_GET_ID   = 10'b00_0100_0000,
    PH_GET_MOVE = 10'b00_1000_0000,
    PH_SKIP_OBJ = 10'b01_0000_0000,
    PH_SKIP     = 10'b10_0000_0000
  } phase_e;

  // Accepted structure handed from the parser to the dedup sequencer
  typedef struct packed {
    logic [47:0]        mac;
    logic [7:0]         id;
    logic signed [7:0]  rssi;
    logic               motion;
  } fin_t;

  // One sender table entry
  typedef struct packed {
    logic [47:0] mac;
    logic [7:0]  last_id;
  } entry_t;

endpackage

// File: src/bsdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: src/bsdf_parse.sv
// Byte-wise walker of AD structures and service-data object parser.
module bsdf_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          ad_byte_i,
  input  logic                first_byte_i,
  input  logic                last_byte_i,
  input  logic [47:0]         sender_address_i,
  input  logic signed [7:0]   signal_strength_i,
  input  logic [15:0]         service_uuid_i,
  input  logic [7:0]          trigger_byte_i,
  output logic                fin_valid_o,
  output bsdf_pkg::fin_t      fin_o
);

  bsdf_pkg::phase_e phase_q, phase_d;
  logic [7:0]  off_q, off_d;
  logic        stopped_q, stopped_d;
  logic [15:0] uuid_q, uuid_d;
  logic [2:0]  obl_q, obl_d;
  logic        have_id_q, have_id_d;
  logic        have_mv_q, have_mv_d;
  logic        err_q, err_d;
  logic [7:0]  cap_id_q, cap_id_d;
  logic [7:0]  cap_mv_q, cap_mv_d;

  always_comb begin
    bsdf_pkg::phase_e ph;
    bsdf_pkg::phase_e nxt;
    logic             stop_eff;
    logic [7:0]       off;
    logic [7:0]       off_dec;
    logic [2:0]       need;

    phase_d     = phase_q;
    off_d       = off_q;
    stopped_d   = stopped_q;
    uuid_d      = uuid_q;
    obl_d       = obl_q;
    have_id_d   = have_id_q;
    have_mv_d   = have_mv_q;
    err_d       = err_q;
    cap_id_d    = cap_id_q;
    cap_mv_d    = cap_mv_q;
    fin_valid_o = 1'b0;
    nxt         = bsdf_pkg::PH_SKIP;
    need        = 3'd0;

    // A first mark restarts the walk
    stop_eff = first_byte_i ? 1'b0 : stopped_q;
    ph       = first_byte_i ? bsdf_pkg::PH_LEN : phase_q;
    off      = first_byte_i ? 8'd0 : off_q;
    off_dec  = off - 8'd1;

    if (accept_i) begin
      stopped_d = stop_eff;
      phase_d   = ph;
      off_d     = off;
      if (!stop_eff) begin
        if (ph == bsdf_pkg::PH_LEN) begin
          if (ad_byte_i == 8'd0) begin
            stopped_d = 1'b1;
          end else begin
            off_d   = ad_byte_i;
            phase_d = bsdf_pkg::PH_TYPE;
          end
        end else begin
          off_d = off_dec;
          case (ph)
            bsdf_pkg::PH_TYPE: begin
              phase_d = (ad_byte_i == bsdf_pkg::AD_TYPE_SVC16 && off_dec >= 8'd2) ?
                        bsdf_pkg::PH_UUID_LO : bsdf_pkg::PH_SKIP;
            end
            bsdf_pkg::PH_UUID_LO: begin
              uuid_d  = {8'd0, ad_byte_i};
              phase_d = bsdf_pkg::PH_UUID_HI;
            end
            bsdf_pkg::PH_UUID_HI: begin
              uuid_d  = {ad_byte_i, uuid_q[7:0]};
              phase_d = ({ad_byte_i, uuid_q[7:0]} == service_uuid_i) ?
                        bsdf_pkg::PH_TRIG : bsdf_pkg::PH_SKIP;
            end
            bsdf_pkg::PH_TRIG: begin
              have_id_d = 1'b0;
              have_mv_d = 1'b0;
              cap_id_d  = 8'd0;
              cap_mv_d  = 8'd0;
              if (ad_byte_i != trigger_byte_i) begin
                err_d   = 1'b1;
                phase_d = bsdf_pkg::PH_SKIP;
              end else begin
                err_d   = 1'b0;
                phase_d = bsdf_pkg::PH_OBJ;
              end
            end
            bsdf_pkg::PH_OBJ: begin
              case (ad_byte_i)
                bsdf_pkg::OBJ_PACKET_ID: begin need = 3'd1; nxt = bsdf_pkg::PH_GET_ID; end
                bsdf_pkg::OBJ_MOVING:    begin need = 3'd1; nxt = bsdf_pkg::PH_GET_MOVE; end
                bsdf_pkg::OBJ_SKIP_1B:   begin need = 3'd1; nxt = bsdf_pkg::PH_SKIP_OBJ; end
                bsdf_pkg::OBJ_SKIP_4B:   begin need = 3'd4; nxt = bsdf_pkg::PH_SKIP_OBJ; end
                default:                 begin need = 3'd0; nxt = bsdf_pkg::PH_SKIP; end
              endcase
              if (nxt == bsdf_pkg::PH_SKIP || {5'd0, need} > off_dec) begin
                err_d   = 1'b1;
                phase_d = bsdf_pkg::PH_SKIP;
              end else begin
                obl_d   = need;
                phase_d = nxt;
              end
            end
            bsdf_pkg::PH_GET_ID, bsdf_pkg::PH_GET_MOVE, bsdf_pkg::PH_SKIP_OBJ: begin
              if (ph == bsdf_pkg::PH_GET_ID) begin
                cap_id_d  = ad_byte_i;
                have_id_d = 1'b1;
              end else if (ph == bsdf_pkg::PH_GET_MOVE) begin
                cap_mv_d  = ad_byte_i;
                have_mv_d = 1'b1;
              end
              obl_d   = obl_q - 3'd1;
              phase_d = (obl_d == 3'd0) ? bsdf_pkg::PH_OBJ : bsdf_pkg::PH_SKIP_OBJ;
            end
            default: ;
          endcase
          // structure complete
          if (off_dec == 8'd0) begin
            if (ph inside {bsdf_pkg::PH_TRIG, bsdf_pkg::PH_OBJ, bsdf_pkg::PH_GET_ID,
                           bsdf_pkg::PH_GET_MOVE, bsdf_pkg::PH_SKIP_OBJ}) begin
              fin_valid_o = !err_d && have_id_d && have_mv_d &&
                            (phase_d == bsdf_pkg::PH_OBJ);
            end
            phase_d = bsdf_pkg::PH_LEN;
          end
        end
      end
      if (last_byte_i) begin
        stopped_d = 1'b1;
      end
    end
  end

  assign fin_o.mac    = sender_address_i;
  assign fin_o.id     = cap_id_d;
  assign fin_o.rssi   = signal_strength_i;
  assign fin_o.motion = (cap_mv_d == 8'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bsdf_pkg::PH_LEN;
      off_q     <= 8'd0;
      stopped_q <= 1'b0;
      uuid_q    <= 16'd0;
      obl_q     <= 3'd0;
      have_id_q <= 1'b0;
      have_mv_q <= 1'b0;
      err_q     <= 1'b0;
      cap_id_q  <= 8'd0;
      cap_mv_q  <= 8'd0;
    end else begin
      phase_q   <= phase_d;
      off_q     <= off_d;
      stopped_q <= stopped_d;
      uuid_q    <= uuid_d;
      obl_q     <= obl_d;
      have_id_q <= have_id_d;
      have_mv_q <= have_mv_d;
      err_q     <= err_d;
      cap_id_q  <= cap_id_d;
      cap_mv_q  <= cap_mv_d;
    end
  end

endmodule

// File: src/ble_service_data_filter_dedup.sv
// Top level: service-data filter with per-sender packet id deduplication.
//
// Input channel (in_valid_i/in_ready_o): one advertising report byte per
// transfer, with first/last marks, sender address and signal strength.
// Output channel (out_valid_o/out_ready_i): at most one result per byte,
// raised when a matching service-data structure carries a new packet id.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 service UUID, 1 trigger byte). The user must write only while idle;
// the block itself does not enforce this.
// A byte that completes an accepted structure starts a table search: one
// sequencer walks the sender table through a single RAM read port and one
// shared 48-bit address comparator, passing over free entries and reading
// and comparing used ones until the first match or the end of the table,
// then updates the table and, for a new packet id, loads the output.
// in_ready_o stays low from the start of the search until the sequencer
// is back in idle.
// Reset empties the table at once (valid flops), restores the register
// defaults and restarts the walker. A result waiting in the output
// register does not block further bytes; only a second result stalls the
// sequencer until the receiver takes the first.
module ble_service_data_filter_dedup #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ad_byte_i,
  input  logic               first_byte_i,
  input  logic               last_byte_i,
  input  logic [47:0]        sender_address_i,
  input  logic signed [7:0]  signal_strength_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [47:0]        sender_mac_o,
  output logic [7:0]         packet_number_o,
  output logic signed [7:0]  report_rssi_o,
  output logic               is_motion_event_o,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_wdata_i
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam int EW = $bits(bsdf_pkg::entry_t);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_CHECK  = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_EMIT   = 5'b10000
  } seq_e;

  seq_e state_q, state_d;

  logic [15:0] svc_uuid_q;
  logic [7:0]  trig_byte_q;

  logic                 accept;
  logic                 fin_valid;
  bsdf_pkg::fin_t       fin;
  bsdf_pkg::fin_t       job_q;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [IW-1:0]  empty_q, empty_d;
  logic           have_empty_q, have_empty_d;
  logic           hit_q, hit_d;
  logic [IW-1:0]  hit_idx_q, hit_idx_d;
  logic [7:0]     hit_id_q, hit_id_d;

  logic           ram_we, ram_re;
  logic [IW-1:0]  ram_waddr;
  logic [EW-1:0]  ram_rdata;
  bsdf_pkg::entry_t rd_entry;
  bsdf_pkg::entry_t wr_entry;

  logic           out_valid_q;
  logic           load_out;

  logic [7:0]     stored_id;
  logic           slot_ok;
  logic           scan_end;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  bsdf_parse u_parse (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .ad_byte_i         (ad_byte_i),
    .first_byte_i      (first_byte_i),
    .last_byte_i       (last_byte_i),
    .sender_address_i  (sender_address_i),
    .signal_strength_i (signal_strength_i),
    .service_uuid_i    (svc_uuid_q),
    .trigger_byte_i    (trig_byte_q),
    .fin_valid_o       (fin_valid),
    .fin_o             (fin)
  );

  // Sender table: {address, last id}; occupancy kept in valid_q
  assign wr_entry.mac     = job_q.mac;
  assign wr_entry.last_id = job_q.id;
  assign rd_entry         = bsdf_pkg::entry_t'(ram_rdata);

  bsdf_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign scan_end  = (cnt_q == CW'(TABLE_ENTRIES));
  assign stored_id = hit_q ? hit_id_q : bsdf_pkg::NEW_ENTRY_ID;
  assign slot_ok   = hit_q || have_empty_q;
  assign ram_waddr = hit_q ? hit_idx_q : empty_q;

  // Search sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    empty_d      = empty_q;
    have_empty_d = have_empty_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_id_d     = hit_id_q;
    valid_d      = valid_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    load_out     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept && fin_valid) begin
          cnt_d        = '0;
          have_empty_d = 1'b0;
          hit_d        = 1'b0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_UPDATE;
        end else if (valid_q[cnt_q[IW-1:0]]) begin
          ram_re  = 1'b1;
          state_d = ST_CHECK;
        end else begin
          // first free slot, in case the sender is unknown
          if (!have_empty_q) begin
            have_empty_d = 1'b1;
            empty_d      = cnt_q[IW-1:0];
          end
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_CHECK: begin
        if (rd_entry.mac == job_q.mac) begin
          hit_d     = 1'b1;
          hit_idx_d = cnt_q[IW-1:0];
          hit_id_d  = rd_entry.last_id;
          state_d   = ST_UPDATE;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = ST_SCAN;
        end
      end
      ST_UPDATE: begin
        // full table with unknown sender: packet dropped
        if (slot_ok) begin
          ram_we = !hit_q || (stored_id != job_q.id);
          if (!hit_q) begin
            valid_d[empty_q] = 1'b1;
          end
        end
        state_d = (slot_ok && stored_id != job_q.id) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      empty_q      <= '0;
      have_empty_q <= 1'b0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      svc_uuid_q   <= bsdf_pkg::SERVICE_UUID_RST;
      trig_byte_q  <= bsdf_pkg::TRIGGER_BYTE_RST;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      empty_q      <= empty_d;
      have_empty_q <= have_empty_d;
      hit_q        <= hit_d;
      hit_idx_q    <= hit_idx_d;
      valid_q      <= valid_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          bsdf_pkg::CFG_SERVICE_UUID: svc_uuid_q  <= cfg_wdata_i;
          bsdf_pkg::CFG_TRIGGER_BYTE: trig_byte_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hit_id_q <= hit_id_d;
    if (accept && fin_valid) begin
      job_q <= fin;
    end
    if (load_out) begin
      sender_mac_o      <= job_q.mac;
      packet_number_o   <= job_q.id;
      report_rssi_o     <= job_q.rssi;
      is_motion_event_o <= job_q.motion;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
